>>> design/psu_pkg.sv
// Shared types and constants for the PNG scanline unfilter block.
`default_nettype none

package psu_pkg;

    // Storage limits
    localparam int MAX_LINE_BYTES  = 8192;
    localparam int MAX_PIXEL_BYTES = 8;

    // Derived widths
    localparam int POS_W      = $clog2(MAX_LINE_BYTES);
    localparam int LINE_CNT_W = $clog2(MAX_LINE_BYTES + 1);
    localparam int PIX_IDX_W  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    // Configuration port
    localparam int CFG_LINE_W = 14;
    localparam int CFG_PIX_W  = 4;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES = 1'b1;

    // Filter type codes
    localparam logic [7:0] FILT_NONE  = 8'd0;
    localparam logic [7:0] FILT_SUB   = 8'd1;
    localparam logic [7:0] FILT_UP    = 8'd2;
    localparam logic [7:0] FILT_AVG   = 8'd3;
    localparam logic [7:0] FILT_PAETH = 8'd4;

    // One byte of the filtered stream
    typedef struct packed {
        logic [7:0] data_byte;
        logic       image_start;
    } t_in_item;

    // One reconstructed byte
    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       line_end;
        logic       bad_filter;
    } t_out_item;

endpackage

`default_nettype wire

>>> design/psu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, holds its data while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> design/psu_predict.sv
// Filter prediction and byte reconstruction (None, Sub, Up, Average, Paeth).
`default_nettype none

module psu_predict (
    input  wire logic [7:0] i_filter,
    input  wire logic [7:0] i_x,
    input  wire logic [7:0] i_a,
    input  wire logic [7:0] i_b,
    input  wire logic [7:0] i_c,
    output logic      [7:0] o_byte,
    output logic            o_bad
);

    logic signed [9:0] d_bc;
    logic signed [9:0] d_ac;
    logic signed [9:0] d_abc;
    logic [8:0]        da;
    logic [8:0]        db;
    logic [8:0]        dc;
    logic [7:0]        paeth;
    logic [8:0]        avg_sum;

    // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
    always_comb begin
        d_bc  = $signed({2'b00, i_b}) - $signed({2'b00, i_c});
        d_ac  = $signed({2'b00, i_a}) - $signed({2'b00, i_c});
        d_abc = d_ac + d_bc;
        da    = d_bc[9]  ? 9'(-d_bc)  : d_bc[8:0];
        db    = d_ac[9]  ? 9'(-d_ac)  : d_ac[8:0];
        dc    = d_abc[9] ? 9'(-d_abc) : d_abc[8:0];
        // ties go to left, then above
        priority if (da <= db && da <= dc) begin
            paeth = i_a;
        end else if (db <= dc) begin
            paeth = i_b;
        end else begin
            paeth = i_c;
        end
    end

    assign avg_sum = {1'b0, i_a} + {1'b0, i_b};

    // Reconstruction by filter type
    always_comb begin
        o_bad = 1'b0;
        unique case (i_filter)
            psu_pkg::FILT_NONE:  o_byte = i_x;
            psu_pkg::FILT_SUB:   o_byte = i_x + i_a;
            psu_pkg::FILT_UP:    o_byte = i_x + i_b;
            psu_pkg::FILT_AVG:   o_byte = i_x + avg_sum[8:1];
            psu_pkg::FILT_PAETH: o_byte = i_x + paeth;
            default: begin
                o_byte = 8'd0;
                o_bad  = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/png_scanline_unfilter.sv
// Top level of the PNG scanline unfilter: line tracking, history, line store.
//
// Input channel (i_in_valid / o_in_stall / i_in_item) takes the decompressed,
// filtered image stream one byte per transfer. The first byte of every line
// is its filter type and produces no output; image_start on a byte restarts
// at the first line of an image. Each following byte yields one output
// transfer (o_out_valid / i_out_stall / o_out_item) with the reconstructed
// byte, a line_end flag on the last byte of a line and bad_filter for filter
// types of 5 or more (byte forced to zero).
// Throughput is one byte per cycle while the receiver does not stall. A data
// byte passes the stage register, where the line store read data arrives,
// then the output register. line_bytes and pixel_bytes are written through
// the configuration port; the user must write them only while the block is
// idle, which the block itself does not enforce. Zero counts as 1, larger
// values saturate to the maximum.
// Reset restores both to 1, waits for a filter byte and marks the first line.
// The line store itself needs no clearing pass: the above byte of the first
// line is forced to zero.
// When the receiver stalls, the output register holds; a second data byte
// waits in the stage register and the input channel stalls after that.
`default_nettype none

module png_scanline_unfilter (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input stream
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire psu_pkg::t_in_item                 i_in_item,
    // output stream
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output psu_pkg::t_out_item                     o_out_item,
    // configuration
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [psu_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [psu_pkg::CFG_DATA_W-1:0]    i_cfg_wr_data
);

    localparam int POS_W      = psu_pkg::POS_W;
    localparam int LINE_CNT_W = psu_pkg::LINE_CNT_W;
    localparam int PIX_IDX_W  = psu_pkg::PIX_IDX_W;
    localparam int NPIX       = psu_pkg::MAX_PIXEL_BYTES;

    // configuration registers (stored already clamped)
    logic [LINE_CNT_W-1:0] r_lb;
    logic [PIX_IDX_W-1:0]  r_pb_m1;
    logic [psu_pkg::CFG_LINE_W-1:0] cfg_lb;
    logic [psu_pkg::CFG_PIX_W-1:0]  cfg_pb;

    // line tracking
    logic             r_await, n_await;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_first, n_first;
    logic [7:0]       r_filter, n_filter;

    // stage register
    logic             r_s1_vld;
    logic [7:0]       r_s1_data;
    logic [POS_W-1:0] r_s1_pos;
    logic             r_s1_first;
    logic [7:0]       r_s1_filter;
    logic             r_s1_last;
    logic             r_s1_aok;

    // histories
    logic [7:0] r_left [NPIX];
    logic [7:0] r_above_left [NPIX];

    // output register
    logic               r_out_vld;
    psu_pkg::t_out_item r_out;

    logic       out_free;
    logic       s1_adv;
    logic       acc;
    logic       is_filter;
    logic       acc_data;
    logic       last_now;
    logic [7:0] ram_q;
    logic [7:0] a_byte;
    logic [7:0] b_byte;
    logic [7:0] c_byte;
    logic [7:0] rec_byte;
    logic       rec_bad;

    // handshake
    assign out_free   = !r_out_vld || !i_out_stall;
    assign s1_adv     = r_s1_vld && out_free;
    assign o_in_stall = r_s1_vld && !out_free;
    assign acc        = i_in_valid && !o_in_stall;
    assign is_filter  = i_in_item.image_start || r_await;
    assign acc_data   = acc && !is_filter;
    assign last_now   = (LINE_CNT_W'(r_pos) + LINE_CNT_W'(1)) >= r_lb;

    // configuration writes with clamping
    assign cfg_lb = i_cfg_wr_data[psu_pkg::CFG_LINE_W-1:0];
    assign cfg_pb = i_cfg_wr_data[psu_pkg::CFG_PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lb    <= LINE_CNT_W'(1);
            r_pb_m1 <= '0;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_idx == psu_pkg::REG_LINE_BYTES) begin
                if (cfg_lb == '0) begin
                    r_lb <= LINE_CNT_W'(1);
                end else if (32'(cfg_lb) > psu_pkg::MAX_LINE_BYTES) begin
                    r_lb <= LINE_CNT_W'(psu_pkg::MAX_LINE_BYTES);
                end else begin
                    r_lb <= LINE_CNT_W'(cfg_lb);
                end
            end else begin
                if (cfg_pb == '0) begin
                    r_pb_m1 <= '0;
                end else if (32'(cfg_pb) > NPIX) begin
                    r_pb_m1 <= PIX_IDX_W'(NPIX - 1);
                end else begin
                    r_pb_m1 <= PIX_IDX_W'(cfg_pb - 1'b1);
                end
            end
        end
    end

    // line position update at each accepted byte
    always_comb begin
        n_await  = r_await;
        n_pos    = r_pos;
        n_first  = r_first;
        n_filter = r_filter;
        if (acc) begin
            if (is_filter) begin
                n_filter = i_in_item.data_byte;
                n_await  = 1'b0;
                n_pos    = '0;
                if (i_in_item.image_start) begin
                    n_first = 1'b1;
                end
            end else if (last_now) begin
                n_await = 1'b1;
                n_pos   = '0;
                n_first = 1'b0;
            end else begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await  <= 1'b1;
            r_pos    <= '0;
            r_first  <= 1'b1;
            r_filter <= '0;
        end else begin
            r_await  <= n_await;
            r_pos    <= n_pos;
            r_first  <= n_first;
            r_filter <= n_filter;
        end
    end

    // stage register: data byte plus its line context
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= acc_data || (r_s1_vld && !s1_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_data) begin
            r_s1_data   <= i_in_item.data_byte;
            r_s1_pos    <= r_pos;
            r_s1_first  <= r_first;
            r_s1_filter <= r_filter;
            r_s1_last   <= last_now;
            r_s1_aok    <= r_pos > POS_W'(r_pb_m1);
        end
    end

    // previous line store: read at transfer, written as the byte leaves
    psu_ram #(
        .WIDTH (8),
        .DEPTH (psu_pkg::MAX_LINE_BYTES)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_pos),
        .i_wr_data (rec_byte),
        .i_rd_en   (acc_data),
        .i_rd_addr (r_pos),
        .o_rd_data (ram_q)
    );

    // neighbor bytes
    assign a_byte = r_s1_aok ? r_left[r_pb_m1] : 8'd0;
    assign c_byte = r_s1_aok ? r_above_left[r_pb_m1] : 8'd0;
    assign b_byte = r_s1_first ? 8'd0 : ram_q;

    psu_predict u_predict (
        .i_filter (r_s1_filter),
        .i_x      (r_s1_data),
        .i_a      (a_byte),
        .i_b      (b_byte),
        .i_c      (c_byte),
        .o_byte   (rec_byte),
        .o_bad    (rec_bad)
    );

    // history shift lines, one step per reconstructed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NPIX; k++) begin
                r_left[k]       <= '0;
                r_above_left[k] <= '0;
            end
        end else if (s1_adv) begin
            for (int k = NPIX - 1; k > 0; k--) begin
                r_left[k]       <= r_left[k-1];
                r_above_left[k] <= r_above_left[k-1];
            end
            r_left[0]       <= rec_byte;
            r_above_left[0] <= b_byte;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out.pixel_byte <= rec_byte;
            r_out.line_end   <= r_s1_last;
            r_out.bad_filter <= rec_bad;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // checks
    a_await_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await |-> (r_pos == '0))
        else $error("line position not cleared while waiting for a filter byte");

    a_lb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lb != '0) && (32'(r_lb) <= psu_pkg::MAX_LINE_BYTES))
        else $error("line length register out of range");

    a_stage_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_vld)
        else $error("stage byte left without reaching the output register");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_data && last_now) |=> (r_await && !r_first))
        else $error("last byte of a line did not end the line");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.bad_filter) |-> (o_out_item.pixel_byte == 8'd0))
        else $error("bad filter byte not forced to zero");

endmodule

`default_nettype wire
